// File: design/sha1h_pkg.sv
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants of the SHA-1 message hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1h_pkg;

	localparam int WORD_W      = 32;
	localparam int CNT_W       = 3;
	localparam int BLOCK_WORDS = 16;
	localparam int BLOCK_BYTES = 64;
	localparam int FILL_W      = 6;
	localparam int LEN_W       = 64;
	localparam int ROUND_W     = 7;
	localparam int CHAIN_WORDS = 5;
	localparam int IDX_W       = 3;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [CNT_W-1:0]   cnt_t;
	typedef logic [FILL_W-1:0]  fill_t;
	typedef logic [LEN_W-1:0]   len_t;
	typedef logic [ROUND_W-1:0] round_t;
	typedef logic [IDX_W-1:0]   idx_t;

	localparam word_t INIT_H0 = 32'h67452301;
	localparam word_t INIT_H1 = 32'hEFCDAB89;
	localparam word_t INIT_H2 = 32'h98BADCFE;
	localparam word_t INIT_H3 = 32'h10325476;
	localparam word_t INIT_H4 = 32'hC3D2E1F0;

	localparam word_t K_CH     = 32'h5A827999;
	localparam word_t K_PAR1   = 32'h6ED9EBA1;
	localparam word_t K_MAJ    = 32'h8F1BBCDC;
	localparam word_t K_PAR2   = 32'hCA62C1D6;

	localparam word_t  PAD_WORD    = 32'h80000000;
	localparam cnt_t   MAX_BYTES   = 3'd4;
	localparam fill_t  LEN_OFFSET  = 6'd56;
	localparam round_t LAST_ROUND  = 7'd79;
	localparam idx_t   LAST_IDX    = 3'd4;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_INSERT   = 6'b000010,
		ST_PAD_ZERO = 6'b000100,
		ST_COMPRESS = 6'b001000,
		ST_FOLD     = 6'b010000,
		ST_OUT      = 6'b100000
	} state_t;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		rotl = (x << n) | (x >> (WORD_W - n));
	endfunction

endpackage

`default_nettype wire

// File: design/sha1h_if.sv
// ----------------------------------------------------------------------------
// sha1h stream interfaces
// Valid/ready channels for message words in and digest words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sha1h_in_if import sha1h_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t data_word;
	cnt_t  byte_count;
	logic  end_of_message;

	modport source (output valid, data_word, byte_count, end_of_message, input ready);
	modport sink   (input valid, data_word, byte_count, end_of_message, output ready);
endinterface

interface sha1h_out_if import sha1h_pkg::*; ();
	logic  valid;
	logic  ready;
	word_t digest_word;
	idx_t  word_index;
	logic  last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// File: design/sha1_message_hasher.sv
// ----------------------------------------------------------------------------
// sha1_message_hasher
// SHA-1 over a byte stream delivered in big-endian words, one round a cycle.
// ----------------------------------------------------------------------------
// The block takes message words on msg (0 to 4 bytes each, larger counts
// taken as 4, first byte in bits 31..24; a short word may follow an unaligned
// stream) and, after a transfer with end_of_message set, pads the message and
// returns the five digest words on digest, word_index 0 to 4, last_word on the
// fifth. It then restarts with the initial chaining values, ready for the next
// message. A word is taken without a stall on msg when its bytes fit in the
// current 64-byte block. Filling a block starts the compression: 80 rounds on
// one shared round unit at one round per cycle, then a fold of the result into
// the chaining words (ST_FOLD) and a step that places any bytes left over from
// the word that filled the block (ST_INSERT), during which msg is not ready.
// The end of a message costs one or two more compressions plus the padding
// steps (pad marker byte, then ST_PAD_ZERO), then five digest transfers.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1_message_hasher import sha1h_pkg::*; (
	input  wire          clk,
	input  wire          arst_n,
	sha1h_in_if.sink     msg,
	sha1h_out_if.source  digest
);

	// Control state
	state_t state_q;
	fill_t  fill_q;
	len_t   bitlen_q;
	round_t round_q;
	idx_t   idx_q;
	cnt_t   rem_cnt_q;
	logic   eom_q;
	logic   pad_q;
	logic   final_q;
	word_t  cv_q [CHAIN_WORDS];

	// Payload state
	word_t  sched_q [BLOCK_WORDS];
	word_t  rem_data_q;
	word_t  a_q, b_q, c_q, d_q, e_q;

	// Byte insertion
	word_t  src_data;
	cnt_t   src_cnt;
	logic   src_eom;
	logic   src_pad;
	logic   do_insert;
	logic [FILL_W:0] room;
	logic [FILL_W:0] fill_sum;
	cnt_t   take;
	cnt_t   left;
	word_t  left_data;
	logic   full;
	word_t  ins_buf  [BLOCK_WORDS];
	word_t  zero_buf [BLOCK_WORDS];
	fill_t  off;

	// Round unit
	word_t  w_cur;
	word_t  f_val;
	word_t  k_val;
	word_t  t_val;

	assign msg.ready = (state_q == ST_IDLE);
	assign do_insert = (state_q == ST_IDLE && msg.valid) || (state_q == ST_INSERT);

	// Pick the bytes to place: the new transfer when idle, else what is left over
	always_comb begin
		if (state_q == ST_IDLE) begin
			src_data = msg.data_word;
			src_cnt  = (msg.byte_count > MAX_BYTES) ? MAX_BYTES : msg.byte_count;
			src_eom  = msg.end_of_message;
			src_pad  = 1'b0;
		end else begin
			src_data = rem_data_q;
			src_cnt  = rem_cnt_q;
			src_eom  = eom_q;
			src_pad  = pad_q;
		end
	end

	// Place as many bytes as fit before the end of the block
	always_comb begin
		room      = (FILL_W+1)'(BLOCK_BYTES) - {1'b0, fill_q};
		take      = (room < (FILL_W+1)'(src_cnt)) ? room[CNT_W-1:0] : src_cnt;
		fill_sum  = {1'b0, fill_q} + (FILL_W+1)'(take);
		full      = fill_sum[FILL_W];
		left      = src_cnt - take;
		left_data = src_data << {take, 3'b000};
		off       = '0;
		for (int i = 0; i < BLOCK_WORDS; i++) begin
			ins_buf[i]  = sched_q[i];
			zero_buf[i] = sched_q[i];
		end
		for (int p = 0; p < BLOCK_BYTES; p++) begin
			off = FILL_W'(p) - fill_q;
			if (FILL_W'(p) >= fill_q && off < FILL_W'(take)) begin
				ins_buf[p >> 2][(3 - (p & 3)) * 8 +: 8] =
					src_data[{~off[1:0], 3'b000} +: 8];
			end
			if (FILL_W'(p) >= fill_q) begin
				zero_buf[p >> 2][(3 - (p & 3)) * 8 +: 8] = 8'h00;
			end
		end
		// Length goes into the last two words once it fits in this block
		if (fill_q <= LEN_OFFSET) begin
			zero_buf[BLOCK_WORDS-2] = bitlen_q[LEN_W-1:WORD_W];
			zero_buf[BLOCK_WORDS-1] = bitlen_q[WORD_W-1:0];
		end
	end

	// One SHA-1 round; the schedule window holds the last 16 words, oldest first
	always_comb begin
		if (round_q < round_t'(BLOCK_WORDS)) begin
			w_cur = sched_q[0];
		end else begin
			w_cur = rotl(sched_q[13] ^ sched_q[8] ^ sched_q[2] ^ sched_q[0], 1);
		end
		if (round_q inside {[0:19]}) begin
			f_val = (b_q & c_q) | (~b_q & d_q);
			k_val = K_CH;
		end else if (round_q inside {[20:39]}) begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_PAR1;
		end else if (round_q inside {[40:59]}) begin
			f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_val = K_MAJ;
		end else begin
			f_val = b_q ^ c_q ^ d_q;
			k_val = K_PAR2;
		end
		t_val = rotl(a_q, 5) + f_val + e_q + k_val + w_cur;
	end

	// Sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= '0;
			bitlen_q  <= '0;
			round_q   <= '0;
			idx_q     <= '0;
			rem_cnt_q <= '0;
			eom_q     <= 1'b0;
			pad_q     <= 1'b0;
			final_q   <= 1'b0;
			cv_q[0]   <= INIT_H0;
			cv_q[1]   <= INIT_H1;
			cv_q[2]   <= INIT_H2;
			cv_q[3]   <= INIT_H3;
			cv_q[4]   <= INIT_H4;
		end else begin
			case (state_q)
				ST_IDLE, ST_INSERT: begin
					if (do_insert) begin
						fill_q <= fill_sum[FILL_W-1:0];
						if (!src_pad) begin
							bitlen_q <= bitlen_q + LEN_W'({take, 3'b000});
						end
						eom_q <= src_eom;
						pad_q <= src_pad;
						if (full) begin
							// Block is complete: compress, then resume with the rest
							rem_cnt_q <= left;
							final_q   <= 1'b0;
							round_q   <= '0;
							state_q   <= ST_COMPRESS;
						end else if (!src_eom) begin
							rem_cnt_q <= '0;
							state_q   <= ST_IDLE;
						end else if (!src_pad) begin
							// Append the pad marker byte next
							rem_cnt_q <= cnt_t'(1);
							pad_q     <= 1'b1;
							state_q   <= ST_INSERT;
						end else begin
							rem_cnt_q <= '0;
							state_q   <= ST_PAD_ZERO;
						end
					end
				end
				ST_PAD_ZERO: begin
					fill_q  <= '0;
					final_q <= (fill_q <= LEN_OFFSET);
					round_q <= '0;
					state_q <= ST_COMPRESS;
				end
				ST_COMPRESS: begin
					round_q <= round_q + round_t'(1);
					if (round_q == LAST_ROUND) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					cv_q[0] <= cv_q[0] + a_q;
					cv_q[1] <= cv_q[1] + b_q;
					cv_q[2] <= cv_q[2] + c_q;
					cv_q[3] <= cv_q[3] + d_q;
					cv_q[4] <= cv_q[4] + e_q;
					round_q <= '0;
					idx_q   <= '0;
					state_q <= final_q ? ST_OUT : ST_INSERT;
				end
				ST_OUT: begin
					if (digest.ready) begin
						if (idx_q == LAST_IDX) begin
							// Restart for the next message
							cv_q[0]  <= INIT_H0;
							cv_q[1]  <= INIT_H1;
							cv_q[2]  <= INIT_H2;
							cv_q[3]  <= INIT_H3;
							cv_q[4]  <= INIT_H4;
							fill_q   <= '0;
							bitlen_q <= '0;
							eom_q    <= 1'b0;
							pad_q    <= 1'b0;
							final_q  <= 1'b0;
							idx_q    <= '0;
							state_q  <= ST_IDLE;
						end else begin
							idx_q <= idx_q + idx_t'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Block buffer, working words and leftover bytes
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE, ST_INSERT: begin
				if (do_insert) begin
					for (int i = 0; i < BLOCK_WORDS; i++) begin
						sched_q[i] <= ins_buf[i];
					end
					if (full) begin
						rem_data_q <= left_data;
						a_q <= cv_q[0];
						b_q <= cv_q[1];
						c_q <= cv_q[2];
						d_q <= cv_q[3];
						e_q <= cv_q[4];
					end else if (src_eom && !src_pad) begin
						rem_data_q <= PAD_WORD;
					end
				end
			end
			ST_PAD_ZERO: begin
				for (int i = 0; i < BLOCK_WORDS; i++) begin
					sched_q[i] <= zero_buf[i];
				end
				a_q <= cv_q[0];
				b_q <= cv_q[1];
				c_q <= cv_q[2];
				d_q <= cv_q[3];
				e_q <= cv_q[4];
			end
			ST_COMPRESS: begin
				// Advance the schedule window by one word
				for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
					sched_q[i] <= sched_q[i+1];
				end
				sched_q[BLOCK_WORDS-1] <= w_cur;
				a_q <= t_val;
				b_q <= a_q;
				c_q <= rotl(b_q, 30);
				d_q <= c_q;
				e_q <= d_q;
			end
			default: begin
			end
		endcase
	end

	assign digest.valid       = (state_q == ST_OUT);
	assign digest.digest_word = cv_q[idx_q];
	assign digest.word_index  = idx_q;
	assign digest.last_word   = (idx_q == LAST_IDX);

	// Input and output never open together
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(msg.ready && digest.valid))
		else $error("msg ready while digest words pending");

	// The final digest transfer returns the block to accepting input
	a_ready_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && digest.last_word) |=> msg.ready)
		else $error("not ready after last digest word");

	// Round 79 is always followed by the fold into the chaining words
	a_fold_after_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPRESS && round_q == LAST_ROUND) |=> (state_q == ST_FOLD))
		else $error("compression did not end after 80 rounds");

	// Digest words come out in order, one index per transfer
	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.ready && !digest.last_word) |=>
		(digest.valid && digest.word_index == $past(digest.word_index) + idx_t'(1)))
		else $error("digest word index skipped");

endmodule

`default_nettype wire

// File: tb/sha1h_digest_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha1h_digest_checker
// Watches the message and digest streams, computes the SHA-1 digest of each
// message from the accepted words and compares every digest word against it.
// ----------------------------------------------------------------------------
module sha1h_digest_checker import sha1h_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sha1h_in_if  msg,
	sha1h_out_if digest,
	output int   mismatches,
	output int   pending
);

	typedef struct packed {
		word_t word;
		idx_t  index;
		logic  last;
	} digest_exp_t;

	word_t       chain_h   [CHAIN_WORDS];
	word_t       msg_block [BLOCK_WORDS];
	fill_t       block_fill;
	len_t        msg_bits;
	digest_exp_t digest_due [$];
	digest_exp_t due;
	int          fail_count;

	function automatic void reload_initial();
		chain_h[0] = INIT_H0;
		chain_h[1] = INIT_H1;
		chain_h[2] = INIT_H2;
		chain_h[3] = INIT_H3;
		chain_h[4] = INIT_H4;
		block_fill = '0;
		msg_bits   = '0;
	endfunction

	// 80 rounds over the block, schedule expanded in place
	function automatic void run_rounds();
		word_t a, b, c, d, e, w, f, k, t;
		int r;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (r = 0; r < 80; r++) begin
			if (r < 16) begin
				w = msg_block[r];
			end else begin
				w = msg_block[(r - 3) % 16] ^ msg_block[(r - 8) % 16] ^
				    msg_block[(r - 14) % 16] ^ msg_block[r % 16];
				w = {w[30:0], w[31]};
				msg_block[r % 16] = w;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_CH;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_PAR1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_MAJ;
			end else begin
				f = b ^ c ^ d;
				k = K_PAR2;
			end
			t = {a[26:0], a[31:27]} + f + e + k + w;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] += a;
		chain_h[1] += b;
		chain_h[2] += c;
		chain_h[3] += d;
		chain_h[4] += e;
	endfunction

	function automatic void append_byte(input logic [7:0] value);
		int sh;
		sh = 24 - 8 * block_fill[1:0];
		msg_block[block_fill[5:2]][sh +: 8] = value;
		block_fill = block_fill + 1'b1;
		if (block_fill == '0)
			run_rounds();
	endfunction

	// absorb one accepted message word; queue the digest at end of message
	function automatic void absorb_item(input word_t data, input cnt_t cnt, input logic last);
		int unsigned n;
		int unsigned i;
		digest_exp_t d;
		n = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
		for (i = 0; i < n; i++) begin
			append_byte(data[31 - 8 * i -: 8]);
			msg_bits += 64'd8;
		end
		if (!last)
			return;
		append_byte(8'h80);
		while (block_fill != LEN_OFFSET)
			append_byte(8'h00);
		msg_block[14] = msg_bits[63:32];
		msg_block[15] = msg_bits[31:0];
		run_rounds();
		block_fill = '0;
		for (i = 0; i < CHAIN_WORDS; i++) begin
			d.word  = chain_h[i];
			d.index = idx_t'(i);
			d.last  = (idx_t'(i) == LAST_IDX);
			digest_due.push_back(d);
		end
		reload_initial();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_initial();
			foreach (msg_block[i])
				msg_block[i] = '0;
			digest_due.delete();
			fail_count = 0;
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (msg.valid && msg.ready)
				absorb_item(msg.data_word, msg.byte_count, msg.end_of_message);
			if (digest.valid && digest.ready) begin
				if (digest_due.size() == 0) begin
					$error("digest_word: expected none, actual %h", digest.digest_word);
					fail_count++;
				end else begin
					due = digest_due.pop_front();
					if (digest.digest_word !== due.word) begin
						$error("digest_word: expected %h, actual %h",
						       due.word, digest.digest_word);
						fail_count++;
					end
					if (digest.word_index !== due.index) begin
						$error("word_index: expected %0d, actual %0d",
						       due.index, digest.word_index);
						fail_count++;
					end
					if (digest.last_word !== due.last) begin
						$error("last_word: expected %b, actual %b",
						       due.last, digest.last_word);
						fail_count++;
					end
				end
			end
			mismatches <= fail_count;
			pending    <= digest_due.size();
		end
	end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives whole messages into the SHA-1 hasher with random gaps on the message
// stream and random stalls on the digest stream; a checker beside the block
// computes the digests and counts mismatches, the top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
	import sha1h_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	int          mismatches;
	int          pending;
	bit          quiet;        // set to run a message with no gaps and no stalls
	int unsigned items_sent;   // message words that the block actually uses
	int unsigned msg_len;

	sha1h_in_if  msg_if ();
	sha1h_out_if digest_if ();

	sha1_message_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_if),
		.digest (digest_if)
	);

	sha1h_digest_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg        (msg_if),
		.digest     (digest_if),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offer one message word and hold it until the transfer. Valid stays high
	// into the next word when there is no gap, so it never drops and rises in
	// the same step.
	task automatic send_item(input word_t data, input cnt_t cnt, input logic last);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			msg_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_if.valid          <= 1'b1;
		msg_if.data_word      <= data;
		msg_if.byte_count     <= cnt;
		msg_if.end_of_message <= last;
		@(posedge clk);
		while (!msg_if.ready) @(posedge clk);
		// an empty word before the end is ignored by the block
		if (cnt != 0 || last)
			items_sent++;
	endtask

	// Send a message of the given byte length as full words with a short or
	// empty final word. With noise on, sprinkle in empty words, short words in
	// mid-stream (the stream then runs unaligned) and counts above four.
	task automatic send_message(input int unsigned total, input bit noisy);
		int unsigned left;
		int unsigned n;
		left = total;
		while (left > 0) begin
			if (noisy && $urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 2))
					0: begin
						send_item($urandom(), 3'd0, 1'b0);
					end
					1: begin
						n = $urandom_range(1, (left < 3) ? left : 3);
						send_item($urandom(), cnt_t'(n), 1'b0);
						left -= n;
					end
					default: begin
						if (left >= 4) begin
							send_item($urandom(), cnt_t'($urandom_range(5, 7)), 1'b0);
							left -= 4;
						end
					end
				endcase
				continue;
			end
			n = (left >= 4) ? 4 : left;
			// close on the last data word, or leave a full tail to an empty end
			if (n == left && (n < 4 || $urandom_range(0, 1) == 1)) begin
				send_item($urandom(), cnt_t'(n), 1'b1);
				return;
			end
			send_item($urandom(), cnt_t'(n), 1'b0);
			left -= n;
		end
		send_item($urandom(), 3'd0, 1'b1);
	endtask

	// Digest side: hold ready low for a random stall, then high for a burst.
	initial begin
		int unsigned n;
		digest_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			n = pick_gap();
			if (n != 0) begin
				digest_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			digest_if.ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	// Message side and verdict.
	initial begin
		arst_n                <= 1'b0;
		msg_if.valid          <= 1'b0;
		msg_if.data_word      <= '0;
		msg_if.byte_count     <= '0;
		msg_if.end_of_message <= 1'b0;
		quiet      = 1'b0;
		items_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Empty message: padding only.
		send_item(32'h00000000, 3'd0, 1'b1);
		// "abc" in one short final word
		send_item(32'h61626300, 3'd3, 1'b1);
		// one full final word, all ones and all zeros
		send_item(32'hFFFFFFFF, 3'd4, 1'b1);
		send_item(32'h00000000, 3'd4, 1'b1);
		// counts above four saturate to four bytes
		send_item(32'hA5A5A5A5, 3'd5, 1'b0);
		send_item(32'h5A5A5A5A, 3'd6, 1'b0);
		send_item(32'h0F0F0F0F, 3'd7, 1'b1);
		// empty word in mid-stream, then short words that leave it unaligned;
		// garbage in unused bytes must be dropped
		send_item(32'hDEADBEEF, 3'd0, 1'b0);
		send_item(32'h01FFFFFF, 3'd1, 1'b0);
		send_item(32'h2345FFFF, 3'd2, 1'b0);
		send_item(32'h6789ABCD, 3'd4, 1'b0);
		send_item(32'hEF000000, 3'd1, 1'b1);
		// full words, then an empty final word
		send_item(32'hFFFFFFFF, 3'd4, 1'b0);
		send_item(32'h80000001, 3'd4, 1'b0);
		send_item(32'h12345678, 3'd0, 1'b1);

		// Random part: mostly well-formed messages, about one in three placed
		// on a padding boundary (55/56 bytes: one or two pad blocks; 64: full).
		while (items_sent < 180) begin
			if ($urandom_range(0, 9) < 3) begin
				case ($urandom_range(0, 7))
					0: msg_len = 55;
					1: msg_len = 56;
					2: msg_len = 57;
					3: msg_len = 63;
					4: msg_len = 64;
					5: msg_len = 65;
					6: msg_len = 119;
					default: msg_len = 120;
				endcase
			end else begin
				msg_len = $urandom_range(0, 48);
			end
			quiet = ($urandom_range(0, 3) == 0);
			send_message(msg_len, $urandom_range(0, 3) == 0);
		end
		quiet = 1'b0;
		msg_if.valid <= 1'b0;

		// Let the checker see the last transfer, drain the digests, then
		// watch a while longer for stray output.
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
design/sha1h_pkg.sv
design/sha1h_if.sv
design/sha1_message_hasher.sv
tb/sha1h_digest_checker.sv
tb/tb_top.sv
